@@ hw/rtl/jos_pkg.sv @@
`default_nettype none
// Shared types and constants for the jet overlap and kinematic selector.
// No dependencies; imported by every module of the block.
package jos_pkg;

	// Item kinds carried on the input tuser
	typedef enum logic [1:0] {
		CMD_JET      = 2'd0,
		CMD_ELECTRON = 2'd1,
		CMD_MUON     = 2'd2
	} cmd_t;

	// Register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_PT_MIN   = 2'd0;
	localparam logic [1:0] REG_ETA_MAX  = 2'd1;
	localparam logic [1:0] REG_ELEC_DR  = 2'd2;
	localparam logic [1:0] REG_MUON_DR  = 2'd3;

	// Field widths
	localparam int unsigned ETA_W = 16;
	localparam int unsigned PHI_W = 15;
	localparam int unsigned PT_W  = 24;
	localparam int unsigned DR_W  = 15;
	localparam int unsigned PTM_W = 25;

	// Angles in Q3.12 radians
	localparam logic [PHI_W-1:0] PI_Q12     = 15'd12868;
	localparam logic [PHI_W-1:0] TWO_PI_Q12 = 15'd25736;

	// Register reset values
	localparam logic [PTM_W-1:0] PT_MIN_RST  = {PTM_W{1'b1}};
	localparam logic [ETA_W-1:0] ETA_MAX_RST = 16'h8000;

	// Kinematic pass bits of the stored jet
	typedef struct packed {
		logic jvf_ok;
		logic eta_ok;
		logic pt_ok;
	} kin_t;

	// Output tdata bit positions
	localparam int unsigned OUT_ELEC = 0;
	localparam int unsigned OUT_MUON = 1;
	localparam int unsigned OUT_PT   = 2;
	localparam int unsigned OUT_ETA  = 3;
	localparam int unsigned OUT_JVF  = 4;
	localparam int unsigned OUT_ACC  = 5;

endpackage
`default_nettype wire

@@ hw/rtl/jos_dr_cmp.sv @@
`default_nettype none
// Squared delta-R compare of one particle against the stored jet.
// Depends on jos_pkg for widths and the pi constants.
module jos_dr_cmp
	import jos_pkg::*;
(
	input  wire logic signed [ETA_W-1:0] eta,
	input  wire logic signed [PHI_W-1:0] phi,
	input  wire logic signed [ETA_W-1:0] jet_eta,
	input  wire logic signed [PHI_W-1:0] jet_phi,
	input  wire logic        [DR_W-1:0]  thr,
	output logic                         in_cone
);

	logic signed [ETA_W:0]   deta_s;
	logic        [ETA_W-1:0] deta;
	logic signed [PHI_W:0]   dphi_s;
	logic        [PHI_W-1:0] dphi_abs;
	logic        [PHI_W-1:0] dphi_wrap;
	logic        [PHI_W-1:0] dphi;
	logic        [2*ETA_W-1:0] deta_sq;
	logic        [2*PHI_W-1:0] dphi_sq;
	logic        [2*ETA_W:0]   dist_sq;
	logic        [2*DR_W-1:0]  thr_sq;

	// absolute differences
	assign deta_s   = {eta[ETA_W-1], eta} - {jet_eta[ETA_W-1], jet_eta};
	assign deta     = deta_s[ETA_W] ? ETA_W'(-deta_s) : deta_s[ETA_W-1:0];
	assign dphi_s   = {phi[PHI_W-1], phi} - {jet_phi[PHI_W-1], jet_phi};
	assign dphi_abs = dphi_s[PHI_W] ? PHI_W'(-dphi_s) : dphi_s[PHI_W-1:0];

	// fold phi difference into 0..pi
	assign dphi_wrap = (dphi_abs > TWO_PI_Q12) ? dphi_abs - TWO_PI_Q12 : dphi_abs;
	assign dphi      = (dphi_wrap > PI_Q12) ? TWO_PI_Q12 - dphi_wrap : dphi_wrap;

	// exact squared compare
	assign deta_sq = deta * deta;
	assign dphi_sq = dphi * dphi;
	assign thr_sq  = thr * thr;
	assign dist_sq = {1'b0, deta_sq} + {3'b000, dphi_sq};
	assign in_cone = dist_sq < {3'b000, thr_sq};

endmodule
`default_nettype wire

@@ hw/rtl/jos_kin.sv @@
`default_nettype none
// Kinematic cuts of a jet item: pt, |eta| and the vertex-fraction bit.
// Depends on jos_pkg for kin_t and field widths.
module jos_kin
	import jos_pkg::*;
(
	input  wire logic signed [ETA_W-1:0] eta,
	input  wire logic        [PT_W-1:0]  pt,
	input  wire logic                    jvf_pass,
	input  wire logic        [PTM_W-1:0] pt_min,
	input  wire logic        [ETA_W-1:0] eta_max,
	output kin_t                         kin
);

	logic signed [PTM_W:0] pt_ext;
	logic signed [PTM_W:0] ptm_ext;
	logic        [ETA_W:0] eta_abs;
	logic signed [ETA_W:0] eta_ext;

	// pt strictly above the signed minimum
	assign pt_ext  = {2'b00, pt};
	assign ptm_ext = {pt_min[PTM_W-1], pt_min};

	// |eta| needs one extra bit for the most negative code
	assign eta_ext = {eta[ETA_W-1], eta};
	assign eta_abs = eta_ext[ETA_W] ? (ETA_W+1)'(-eta_ext) : eta_ext;

	assign kin.pt_ok  = pt_ext > ptm_ext;
	assign kin.eta_ok = eta_abs < {1'b0, eta_max};
	assign kin.jvf_ok = jvf_pass;

endmodule
`default_nettype wire

@@ hw/rtl/jet_overlap_and_kinematic_selector.sv @@
`default_nettype none
// Top level of the jet overlap and kinematic selector.
// Depends on jos_pkg, jos_dr_cmp and jos_kin.
//
// A jet item (tuser = 0) stores the jet and its pt, |eta| and vertex-fraction
// cuts and clears the overlap flags; electron (1) and muon (2) items compare
// squared delta-R against the stored jet and set their flag when strictly
// inside the threshold. An item with tlast set yields one result byte:
// bit0 electron_ok, bit1 muon_ok, bit2 pt_ok, bit3 eta_ok, bit4 jvf_ok,
// bit5 accepted. Each item sits in the input register while the compare
// logic works on it, so one item is taken every clock while the input is
// not stalled; a result goes to the output register as its last item leaves
// the input register. Input stalls only while a result sits unread in the
// output register and the item in the input register is also a last one.
// Registers via APB at 0x0 pt_minimum, 0x4 eta_maximum, 0x8 electron_dr_min,
// 0xC muon_dr_min; write them only while no items are in flight.
module jet_overlap_and_kinematic_selector
	import jos_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input items
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,  // eta[15:0], phi[30:16], pt[54:31], jvf_pass[55]
	input  wire logic [1:0]  s_tuser,  // cmd[1:0]
	input  wire logic        s_tlast,
	// result items
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // electron_ok, muon_ok, pt_ok, eta_ok, jvf_ok,
	                                   // accepted, zeros[7:6]
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	// configuration registers
	logic [PTM_W-1:0] pt_min_q;
	logic [ETA_W-1:0] eta_max_q;
	logic [DR_W-1:0]  elec_dr_q;
	logic [DR_W-1:0]  muon_dr_q;

	// input register
	logic                    s1_valid;
	cmd_t                    cmd_s1;
	logic signed [ETA_W-1:0] eta_s1;
	logic signed [PHI_W-1:0] phi_s1;
	logic        [PT_W-1:0]  pt_s1;
	logic                    jvf_s1;
	logic                    last_s1;

	// jet state
	logic signed [ETA_W-1:0] jet_eta_q;
	logic signed [PHI_W-1:0] jet_phi_q;
	kin_t                    kin_q;
	logic                    elec_seen_q;
	logic                    muon_seen_q;

	// result register
	logic       out_valid_q;
	logic [5:0] out_bits_q;

	logic          s_acc;
	logic          out_free;
	logic          s1_adv;
	logic          in_cone;
	logic [DR_W-1:0] thr;
	kin_t          kin_new;
	kin_t          kin_nx;
	logic          elec_nx;
	logic          muon_nx;
	logic [5:0]    res_bits;

	// APB: always ready, write on the access phase
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_min_q  <= PT_MIN_RST;
			eta_max_q <= ETA_MAX_RST;
			elec_dr_q <= '0;
			muon_dr_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_PT_MIN:  pt_min_q  <= pwdata[PTM_W-1:0];
				REG_ETA_MAX: eta_max_q <= pwdata[ETA_W-1:0];
				REG_ELEC_DR: elec_dr_q <= pwdata[DR_W-1:0];
				REG_MUON_DR: muon_dr_q <= pwdata[DR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_PT_MIN:  prdata = {7'd0, pt_min_q};
			REG_ETA_MAX: prdata = {16'd0, eta_max_q};
			REG_ELEC_DR: prdata = {17'd0, elec_dr_q};
			REG_MUON_DR: prdata = {17'd0, muon_dr_q};
			default:     prdata = '0;
		endcase
	end

	// flow control: only a last item can be held back by the output side
	assign out_free = !out_valid_q || m_tready;
	assign s1_adv   = s1_valid && (!last_s1 || out_free);
	assign s_tready = !s1_valid || s1_adv;
	assign s_acc    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tready) begin
			s1_valid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			cmd_s1  <= cmd_t'(s_tuser);
			eta_s1  <= s_tdata[15:0];
			phi_s1  <= s_tdata[30:16];
			pt_s1   <= s_tdata[54:31];
			jvf_s1  <= s_tdata[55];
			last_s1 <= s_tlast;
		end
	end

	// compare and cut logic
	assign thr = (cmd_s1 == CMD_MUON) ? muon_dr_q : elec_dr_q;

	jos_dr_cmp u_dr (
		.eta     (eta_s1),
		.phi     (phi_s1),
		.jet_eta (jet_eta_q),
		.jet_phi (jet_phi_q),
		.thr     (thr),
		.in_cone (in_cone)
	);

	jos_kin u_kin (
		.eta      (eta_s1),
		.pt       (pt_s1),
		.jvf_pass (jvf_s1),
		.pt_min   (pt_min_q),
		.eta_max  (eta_max_q),
		.kin      (kin_new)
	);

	// next jet state for the item in the input register
	always_comb begin
		kin_nx  = kin_q;
		elec_nx = elec_seen_q;
		muon_nx = muon_seen_q;
		case (cmd_s1)
			CMD_JET: begin
				kin_nx  = kin_new;
				elec_nx = 1'b0;
				muon_nx = 1'b0;
			end
			CMD_ELECTRON: elec_nx = elec_seen_q || in_cone;
			CMD_MUON:     muon_nx = muon_seen_q || in_cone;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jet_eta_q   <= '0;
			jet_phi_q   <= '0;
			kin_q       <= '0;
			elec_seen_q <= 1'b0;
			muon_seen_q <= 1'b0;
		end else if (s1_adv) begin
			if (cmd_s1 == CMD_JET) begin
				jet_eta_q <= eta_s1;
				jet_phi_q <= phi_s1;
			end
			kin_q       <= kin_nx;
			elec_seen_q <= elec_nx;
			muon_seen_q <= muon_nx;
		end
	end

	// result byte
	always_comb begin
		res_bits           = '0;
		res_bits[OUT_ELEC] = !elec_nx;
		res_bits[OUT_MUON] = !muon_nx;
		res_bits[OUT_PT]   = kin_nx.pt_ok;
		res_bits[OUT_ETA]  = kin_nx.eta_ok;
		res_bits[OUT_JVF]  = kin_nx.jvf_ok;
		res_bits[OUT_ACC]  = !elec_nx && !muon_nx && kin_nx.pt_ok && kin_nx.eta_ok
			&& kin_nx.jvf_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && last_s1) begin
			out_bits_q <= res_bits;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_bits_q};

endmodule
`default_nettype wire

@@ hw/rtl/jos_checker.sv @@
`default_nettype none
// Port-level checks of the jet overlap and kinematic selector, bound to it.
// Depends on jos_pkg for the result bit positions.
module jos_checker
	import jos_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tready,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata
);

	// a held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// accepted is the AND of the five cut bits
	a_acc_and: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_ACC] == (m_tdata[OUT_ELEC] && m_tdata[OUT_MUON]
			&& m_tdata[OUT_PT] && m_tdata[OUT_ETA] && m_tdata[OUT_JVF]))
		else $error("accepted bit disagrees with cut bits");

	// pad bits stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:6] == 2'b00)
		else $error("result pad bits set");

	// input only stalls behind an unread result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

endmodule

bind jet_overlap_and_kinematic_selector jos_checker u_jos_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

@@ test/jos_cut_checker.sv @@
`timescale 1ns / 1ps
// Checker for the jet overlap and kinematic selector: watches the input, result
// and register channels, predicts the cut bits and compares them. Uses jos_pkg.
module jos_cut_checker
	import jos_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [55:0] s_tdata,  // eta[15:0], phi[30:16], pt[54:31], jvf_pass[55]
	input  logic [1:0]  s_tuser,  // cmd[1:0]
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,  // electron_ok, muon_ok, pt_ok, eta_ok, jvf_ok,
	                              // accepted, zeros[7:6]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          errors,
	output int          pending,
	output int          results_seen,
	output int          jets_accepted
);

	localparam int PRINT_CAP = 200;

	// Bit order matches the result byte: electron_ok in bit 0
	typedef struct packed {
		logic accepted;
		logic jvf_ok;
		logic eta_ok;
		logic pt_ok;
		logic muon_ok;
		logic elec_ok;
	} cut_bits_t;

	cut_bits_t cut_results_due[$];

	// Stored jet and overlap flags
	logic signed [ETA_W-1:0] jet_eta;
	logic signed [PHI_W-1:0] jet_phi;
	kin_t                    jet_kin;
	logic                    elec_hit;
	logic                    muon_hit;

	// Copy of the register file
	logic [PTM_W-1:0] pt_min;
	logic [ETA_W-1:0] eta_max;
	logic [DR_W-1:0]  elec_dr;
	logic [DR_W-1:0]  muon_dr;

	task automatic flag_error(input string msg);
		if (errors < PRINT_CAP)
			$display("jos_cut_checker: %0t ns: %s", $time, msg);
		errors++;
	endtask

	// Squared delta-R strictly inside the threshold; phi distance folded to 0..pi
	function automatic bit near_jet(input logic signed [ETA_W-1:0] eta,
		input logic signed [PHI_W-1:0] phi, input logic [DR_W-1:0] thr);
		longint deta;
		longint dphi;
		deta = longint'(eta) - longint'(jet_eta);
		dphi = longint'(phi) - longint'(jet_phi);
		if (deta < 0)
			deta = -deta;
		if (dphi < 0)
			dphi = -dphi;
		if (dphi > longint'(TWO_PI_Q12))
			dphi -= longint'(TWO_PI_Q12);
		if (dphi > longint'(PI_Q12))
			dphi = longint'(TWO_PI_Q12) - dphi;
		return deta * deta + dphi * dphi < longint'(thr) * longint'(thr);
	endfunction

	// Update the jet state for one item and queue a result on tlast
	task automatic apply_item(input logic [1:0] kind, input logic [55:0] data,
		input logic last);
		logic signed [ETA_W-1:0] eta;
		logic signed [PHI_W-1:0] phi;
		logic [PT_W-1:0]         pt;
		int                      aeta;
		int                      pt_i;
		int                      ptm_i;
		cut_bits_t               due;
		eta  = data[15:0];
		phi  = data[30:16];
		pt   = data[54:31];
		case (kind)
			CMD_JET: begin
				aeta = eta;
				if (aeta < 0)
					aeta = -aeta;
				pt_i  = int'(pt);
				ptm_i = int'($signed(pt_min));
				jet_kin.pt_ok  = pt_i > ptm_i;
				jet_kin.eta_ok = aeta < int'(eta_max);
				jet_kin.jvf_ok = data[55];
				jet_eta  = eta;
				jet_phi  = phi;
				elec_hit = 1'b0;
				muon_hit = 1'b0;
			end
			CMD_ELECTRON: begin
				if (near_jet(eta, phi, elec_dr))
					elec_hit = 1'b1;
			end
			CMD_MUON: begin
				if (near_jet(eta, phi, muon_dr))
					muon_hit = 1'b1;
			end
			default: ;
		endcase
		if (last) begin
			due.elec_ok  = !elec_hit;
			due.muon_ok  = !muon_hit;
			due.pt_ok    = jet_kin.pt_ok;
			due.eta_ok   = jet_kin.eta_ok;
			due.jvf_ok   = jet_kin.jvf_ok;
			due.accepted = due.elec_ok & due.muon_ok & due.pt_ok & due.eta_ok & due.jvf_ok;
			cut_results_due.push_back(due);
		end
	endtask

	// Compare one result byte with the oldest queued expectation
	task automatic check_result(input logic [7:0] d);
		cut_bits_t due;
		string     names[6];
		names = '{"electron_ok", "muon_ok", "pt_ok", "eta_ok", "jvf_ok", "accepted"};
		if (cut_results_due.size() == 0) begin
			flag_error($sformatf("result %02h with nothing expected", d));
			return;
		end
		due = cut_results_due.pop_front();
		results_seen++;
		for (int b = 0; b < 6; b++)
			if (d[b] !== due[b])
				flag_error($sformatf("result %0d: %s is %b, expected %b",
					results_seen, names[b], d[b], due[b]));
		if (d[7:6] !== 2'b00)
			flag_error($sformatf("result %0d: padding bits are %b", results_seen, d[7:6]));
		if (d[OUT_ACC] === 1'b1)
			jets_accepted++;
	endtask

	// Results are handled before inputs so a same-edge item cannot match itself
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jet_eta       = '0;
			jet_phi       = '0;
			jet_kin       = '0;
			elec_hit      = 1'b0;
			muon_hit      = 1'b0;
			pt_min        = PT_MIN_RST;
			eta_max       = ETA_MAX_RST;
			elec_dr       = '0;
			muon_dr       = '0;
			errors        = 0;
			results_seen  = 0;
			jets_accepted = 0;
			cut_results_due.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_PT_MIN:  pt_min  = pwdata[PTM_W-1:0];
					REG_ETA_MAX: eta_max = pwdata[ETA_W-1:0];
					REG_ELEC_DR: elec_dr = pwdata[DR_W-1:0];
					REG_MUON_DR: muon_dr = pwdata[DR_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready)
				check_result(m_tdata);
			if (s_tvalid && s_tready)
				apply_item(s_tuser, s_tdata, s_tlast);
			pending <= cut_results_due.size();
		end
	end

endmodule

@@ test/tb_jet_overlap_and_kinematic_selector.sv @@
`timescale 1ns / 1ps
// Testbench top for the jet overlap and kinematic selector: drives items,
// registers and result back-pressure. Needs jos_pkg, the block and jos_cut_checker.
module tb_jet_overlap_and_kinematic_selector;
	import jos_pkg::*;

	localparam logic [1:0] CMD_UNUSED  = 2'd3;
	localparam int         HOLD_CYCLES = 300;
	localparam int         CYCLE_LIMIT = 400000;
	localparam int         PHASES      = 6;
	localparam int         PHASE_ITEMS = 256;
	localparam int         PI_I        = int'(PI_Q12);
	localparam int         TWO_PI_I    = int'(TWO_PI_Q12);

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata  = '0;  // eta[15:0], phi[30:16], pt[54:31], jvf_pass[55]
	logic [1:0]  s_tuser  = '0;  // cmd[1:0]
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // electron_ok, muon_ok, pt_ok, eta_ok, jvf_ok,
	                             // accepted, zeros[7:6]
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [3:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	int errors;
	int pending;
	int results_seen;
	int jets_accepted;
	int src_idle_pct     = 0;
	int snk_idle_pct     = 0;
	int hold_asked       = 0;
	int hold_done        = 0;
	int hold_left        = 0;
	int items_sent       = 0;
	int settings_written = 0;
	int cycles           = 0;

	always #1 clk = ~clk;

	jet_overlap_and_kinematic_selector dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	jos_cut_checker cut_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.s_tlast       (s_tlast),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.errors        (errors),
		.pending       (pending),
		.results_seen  (results_seen),
		.jets_accepted (jets_accepted)
	);

	// Result side: random stalls, or a long hold-off when one is requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_left <= 0;
			hold_done <= 0;
		end else if (hold_left > 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_asked != hold_done) begin
			m_tready  <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= hold_done + 1;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_jet_overlap_and_kinematic_selector: done, errors");
			$finish;
		end
	end

	// Offer one item, with random idle cycles in front, and wait for it to go in
	task automatic send_item(input logic [1:0] kind, input int eta, input int phi,
		input logic [PT_W-1:0] pt, input logic jvf, input logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tlast  <= last;
		s_tdata  <= {jvf, pt, 15'(phi), 16'(eta)};
		do
			@(posedge clk);
		while (!s_tready);
		items_sent++;
	endtask

	// Setup cycle then access cycle; the register takes the value at the end of the access cycle
	task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		settings_written++;
	endtask

	// Stop offering, wait for every queued result, then let the pipeline empty
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin : stimulus
		int         jet_eta;
		int         jet_phi;
		int         eta;
		int         phi;
		int         n_parts;
		int         target;
		int         pick;
		int         ptm;
		bit         paused;
		logic [1:0] kind;
		logic [23:0] jet_pt;

		paused = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset settings: particles before any jet, unused kind with tlast
		send_item(CMD_ELECTRON, 0, 0, 24'd0, 1'b0, 1'b1);
		send_item(CMD_UNUSED, 100, -100, 24'hFFFFFF, 1'b1, 1'b1);
		settle();

		apb_write(REG_PT_MIN, 32'd1000);
		apb_write(REG_ETA_MAX, 32'd10000);
		apb_write(REG_ELEC_DR, 32'd1638);
		apb_write(REG_MUON_DR, 32'd2048);
		// most negative eta, electron across the pi seam, far muon
		send_item(CMD_JET, -32768, PI_I, 24'hFFFFFF, 1'b1, 1'b0);
		send_item(CMD_ELECTRON, -32668, -PI_I, 24'd0, 1'b0, 1'b0);
		send_item(CMD_MUON, 32767, 0, 24'd0, 1'b0, 1'b1);
		// lone jet with pt equal to the minimum
		send_item(CMD_JET, 32767, -16384, 24'd1000, 1'b0, 1'b1);
		// phi beyond two pi apart, electron on and just inside the threshold
		send_item(CMD_JET, 9999, 16383, 24'd1001, 1'b1, 1'b0);
		send_item(CMD_MUON, 9999, -16384, 24'd0, 1'b0, 1'b0);
		send_item(CMD_ELECTRON, 9999 + 1638, 16383, 24'd0, 1'b0, 1'b0);
		send_item(CMD_ELECTRON, 9999 + 1637, 16383, 24'd0, 1'b0, 1'b1);
		// muon after the result without a new jet: flags carry on
		send_item(CMD_MUON, 9999, 16383, 24'd0, 1'b0, 1'b1);
		send_item(CMD_JET, 0, 0, 24'd0, 1'b1, 1'b0);
		send_item(CMD_UNUSED, 0, 0, 24'd0, 1'b0, 1'b0);
		send_item(CMD_ELECTRON, -20000, 8000, 24'd0, 1'b0, 1'b1);
		// |eta| equal to the maximum
		send_item(CMD_JET, -10000, 0, 24'd500000, 1'b1, 1'b1);
		settle();

		apb_write(REG_PT_MIN, 32'h00FF_FFFF);
		apb_write(REG_ETA_MAX, 32'd0);
		apb_write(REG_ELEC_DR, 32'd32767);
		apb_write(REG_MUON_DR, 32'd32767);
		send_item(CMD_JET, 0, 0, 24'hFFFFFF, 1'b1, 1'b0);
		send_item(CMD_ELECTRON, 32767, 0, 24'd0, 1'b0, 1'b0);
		send_item(CMD_MUON, 32766, 0, 24'd0, 1'b0, 1'b1);

		// Random phases, each with fresh register settings
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			src_idle_pct = (ph < 2) ? 15 : (ph < 4) ? 77 : 0;
			snk_idle_pct = (ph < 2) ? 77 : (ph < 4) ? 15 : 0;

			pick = $urandom_range(5);
			ptm  = (pick == 0) ? -1 : (pick == 1) ? 16777215 : int'($urandom_range(250000));
			apb_write(REG_PT_MIN, 32'(ptm) & 32'h01FF_FFFF);
			pick = $urandom_range(5);
			apb_write(REG_ETA_MAX, (pick == 0) ? 32'd0 : (pick == 1) ? 32'd32768 :
				32'($urandom_range(4096, 24000)));
			pick = $urandom_range(5);
			apb_write(REG_ELEC_DR, (pick == 0) ? 32'd0 : (pick == 1) ? 32'd32767 :
				32'($urandom_range(200, 6000)));
			pick = $urandom_range(5);
			apb_write(REG_MUON_DR, (pick == 0) ? 32'd0 : (pick == 1) ? 32'd32767 :
				32'($urandom_range(200, 6000)));

			// long output stall while items keep coming
			if (ph == 4)
				hold_asked++;

			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				if (ph == PHASES - 1 && !paused && items_sent > target - PHASE_ITEMS / 2) begin
					settle();
					paused = 1'b1;
				end
				if ($urandom_range(99) < 85) begin
					// jet followed by a handful of particles, tlast on the final one
					jet_eta = ($urandom_range(9) == 0) ? int'($signed(16'($urandom))) :
						int'($urandom_range(40000)) - 20000;
					jet_phi = ($urandom_range(9) == 0) ? int'($signed(15'($urandom))) :
						int'($urandom_range(2 * PI_I)) - PI_I;
					jet_pt  = $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(300000));
					n_parts = $urandom_range(5);
					send_item(CMD_JET, jet_eta, jet_phi, jet_pt, 1'($urandom), n_parts == 0);
					for (int k = 1; k <= n_parts; k++) begin
						kind = ($urandom_range(19) == 0) ? CMD_UNUSED :
							($urandom_range(1) ? CMD_ELECTRON : CMD_MUON);
						if ($urandom_range(99) < 60) begin
							// close to the jet, wrapping across the pi seam
							eta = jet_eta + int'($urandom_range(6000)) - 3000;
							phi = jet_phi + int'($urandom_range(6000)) - 3000;
							if (phi > PI_I)
								phi -= TWO_PI_I;
							else if (phi < -PI_I)
								phi += TWO_PI_I;
							if (eta > 32767)
								eta = 32767;
							if (eta < -32768)
								eta = -32768;
							if (phi > 16383)
								phi = 16383;
							if (phi < -16384)
								phi = -16384;
						end else begin
							eta = $signed(16'($urandom));
							phi = $signed(15'($urandom));
						end
						send_item(kind, eta, phi, 24'($urandom), 1'($urandom), k == n_parts);
					end
				end else begin
					// noise: any kind, any fields, random tlast
					send_item(2'($urandom), int'($signed(16'($urandom))),
						int'($signed(15'($urandom))), 24'($urandom), 1'($urandom),
						1'($urandom));
				end
			end
		end

		settle();
		$display("covered %0d input items under %0d register writes; %0d results checked, %0d jets accepted",
			items_sent, settings_written, results_seen, jets_accepted);
		$display("both sides idled in turn, plus a %0d-cycle output hold-off and a full drain",
			HOLD_CYCLES);
		if (errors == 0)
			$display("tb_jet_overlap_and_kinematic_selector: done, clean");
		else
			$display("tb_jet_overlap_and_kinematic_selector: done, errors");
		$finish;
	end

endmodule
